@@ src/vwbf_pkg.sv @@
// Package for the variable-width bit FIFO: sizes, command codes, word types
// and the chunk mask helper. No dependencies.
`timescale 1ns / 1ps
package vwbf_pkg;

    // Store and chunk sizes (CAPACITY must be a power of two)
    localparam int CAPACITY  = 256;
    localparam int MAX_CHUNK = 64;

    // Field widths of the words on the ports
    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int FILL_W = 9;
    localparam int CMD_W  = 2;

    // Pointer width into the circular store
    localparam int IDX_W  = $clog2(CAPACITY);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd3;

    // Input word
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] wr_bits;
        logic [CNT_W-1:0]  bit_count;
    } t_in_item;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] rd_bits;
        logic [CNT_W-1:0]  rd_count;
        logic [FILL_W-1:0] fill_level;
        logic              overflow;
    } t_out_item;

    // Control from the pointer logic to the bit store
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_pos;
        logic [IDX_W-1:0] rd_pos;
        logic [CNT_W-1:0] count;
    } t_store_ctl;

    // Low-order mask of c ones, all ones from DATA_W upwards
    function automatic logic [DATA_W-1:0] chunk_mask(input logic [CNT_W-1:0] c);
        logic [DATA_W-1:0] m;
        if (int'(c) >= DATA_W) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << c) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

@@ src/vwbf_bit_store.sv @@
// Circular bit store: inserts a masked chunk at the tail and extracts a
// chunk from the head through rotating shifts. Depends on vwbf_pkg.
`timescale 1ns / 1ps
module vwbf_bit_store import vwbf_pkg::*; (
    input  logic              i_clk,
    input  t_store_ctl        i_ctl,
    input  logic [DATA_W-1:0] i_wr_bits,
    output logic [DATA_W-1:0] o_rd_bits
);

    localparam int WIDE = 2 * CAPACITY;

    logic [CAPACITY-1:0] r_bits;
    logic [CAPACITY-1:0] n_bits;
    logic [DATA_W-1:0]   cnt_mask;
    logic [WIDE-1:0]     wide_data;
    logic [WIDE-1:0]     wide_mask;
    logic [CAPACITY-1:0] placed_data;
    logic [CAPACITY-1:0] placed_mask;
    logic [WIDE-1:0]     doubled;

    assign cnt_mask = chunk_mask(i_ctl.count);

    // Rotate the chunk and its mask up to the tail position
    always_comb begin
        wide_data   = WIDE'(i_wr_bits & cnt_mask) << i_ctl.wr_pos;
        wide_mask   = WIDE'(cnt_mask) << i_ctl.wr_pos;
        placed_data = wide_data[CAPACITY-1:0] | wide_data[WIDE-1:CAPACITY];
        placed_mask = wide_mask[CAPACITY-1:0] | wide_mask[WIDE-1:CAPACITY];
        n_bits      = i_ctl.wr_en ? ((r_bits & ~placed_mask) | placed_data) : r_bits;
    end

    // Store contents carry no reset; only written bits are ever returned
    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    // Rotate the head down to bit 0 and keep the requested bits
    always_comb begin
        doubled   = {r_bits, r_bits} >> i_ctl.rd_pos;
        o_rd_bits = doubled[DATA_W-1:0] & cnt_mask;
    end

endmodule

@@ src/variable_width_bit_fifo_unit.sv @@
// Variable-width bit FIFO, top level: input register, pointer logic and
// result register around the bit store. Depends on vwbf_pkg, vwbf_bit_store.
// An accepted start loads r_in_valid and the input register; o_done and its
// result word are registered from them. Throughput: one word per cycle, busy stays low.
// Reset (synchronous, active low) empties the FIFO and clears the strobes.
// Bit store contents are not cleared; only bits written since reset are read.
`timescale 1ns / 1ps
module variable_width_bit_fifo_unit import vwbf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_done;
    t_out_item         r_result;
    logic [IDX_W-1:0]  r_head;
    logic [FILL_W-1:0] r_held;

    logic [IDX_W-1:0]  n_head;
    logic [FILL_W-1:0] n_held;
    t_out_item         n_result;
    logic [CNT_W-1:0]  sat_count;
    logic [CNT_W-1:0]  take;
    logic [FILL_W:0]   wr_sum;
    logic              no_room;
    logic              is_write;
    t_store_ctl        store_ctl;
    logic [DATA_W-1:0] front_bits;

    assign busy = 1'b0;

    // Saturate the count and work out room and available bits
    always_comb begin
        sat_count = (int'(r_in.bit_count) > MAX_CHUNK) ? CNT_W'(MAX_CHUNK) : r_in.bit_count;
        wr_sum    = {1'b0, r_held} + (FILL_W + 1)'(sat_count);
        no_room   = int'(wr_sum) > CAPACITY;
        take      = ((FILL_W)'(sat_count) < r_held) ? sat_count : CNT_W'(r_held);
        is_write  = (r_in.cmd == CMD_WRITE);
    end

    // Store control: writes go to the tail, reads come from the head
    always_comb begin
        store_ctl.wr_en  = r_in_valid && is_write && !no_room;
        store_ctl.wr_pos = r_head + r_held[IDX_W-1:0];
        store_ctl.rd_pos = r_head;
        store_ctl.count  = is_write ? sat_count : take;
    end

    vwbf_bit_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_wr_bits (r_in.wr_bits),
        .o_rd_bits (front_bits)
    );

    // Pointer update and result word
    always_comb begin
        n_head              = r_head;
        n_held              = r_held;
        n_result.rd_bits    = '0;
        n_result.rd_count   = '0;
        n_result.overflow   = 1'b0;
        unique case (r_in.cmd)
            CMD_WRITE: begin
                if (no_room) begin
                    n_result.overflow = 1'b1;
                end else begin
                    n_held = wr_sum[FILL_W-1:0];
                end
            end
            CMD_READ: begin
                n_result.rd_bits  = front_bits;
                n_result.rd_count = take;
                n_head            = r_head + IDX_W'(take);
                n_held            = r_held - FILL_W'(take);
            end
            CMD_PEEK: begin
                n_result.rd_bits  = front_bits;
                n_result.rd_count = take;
            end
            CMD_SKIP: begin
                n_result.rd_count = take;
                n_head            = r_head + IDX_W'(take);
                n_held            = r_held - FILL_W'(take);
            end
            default: begin
            end
        endcase
        n_result.fill_level = n_held;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
            r_head     <= '0;
            r_held     <= '0;
        end else begin
            r_in_valid <= start && !busy;
            r_done     <= r_in_valid;
            if (r_in_valid) begin
                r_head <= n_head;
                r_held <= n_held;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ src/vwbf_checker.sv @@
// Port-level checker for the variable-width bit FIFO, bound to the top level.
// Depends on vwbf_pkg and variable_width_bit_fifo_unit.
`timescale 1ns / 1ps
module vwbf_checker import vwbf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_done,
    input t_out_item o_result
);

    // Every accepted word gives exactly one result strobe
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 1) && $past(i_rst_n, 2) |-> o_done == $past(start && !busy, 2))
        else $error("result strobe does not match accepted words");

    // Fill level never exceeds the store size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> int'(o_result.fill_level) <= CAPACITY)
        else $error("fill level beyond capacity");

    // Returned bits above the count are zero, count within chunk size
    a_bits_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> int'(o_result.rd_count) <= MAX_CHUNK
               && (o_result.rd_bits & ~chunk_mask(o_result.rd_count)) == '0)
        else $error("stray bits above returned count");

    // A write returns no bits; overflow only ever flags a write
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_rst_n, 2) && $past(i_item.cmd, 2) == CMD_WRITE
        |-> o_result.rd_count == '0 && o_result.rd_bits == '0)
        else $error("write produced read data");

    a_overflow_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.overflow && $past(i_rst_n, 2) |-> $past(i_item.cmd, 2) == CMD_WRITE)
        else $error("overflow flagged on a non-write");

endmodule

bind variable_width_bit_fifo_unit vwbf_checker u_vwbf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);
